@@ rtl/core/lde_pkg.sv @@
// Shared types and constants of the line editor.
package lde_pkg;

    // Line store geometry.
    localparam int LINE_CAPACITY = 64;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Special byte values.
    localparam logic [7:0] BYTE_CR   = 8'h0d;
    localparam logic [7:0] BYTE_LF   = 8'h0a;
    localparam logic [7:0] BYTE_BS   = 8'h08;
    localparam logic [7:0] PRINT_LOW = 8'h20;
    localparam logic [7:0] PRINT_END = 8'h7f;

    // Result kinds.
    localparam logic [1:0] KIND_REALTIME  = 2'd0;
    localparam logic [1:0] KIND_LINE_CHAR = 2'd1;
    localparam logic [1:0] KIND_EMPTY     = 2'd2;

    // Command codes produced by the classifier.
    localparam logic [1:0] OP_PASS = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_BS   = 2'd2;
    localparam logic [1:0] OP_PUT  = 2'd3;

    // One classified command.
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       lf_after_cr;
    } t_cmd;

endpackage

@@ rtl/core/lde_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module lde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/lde_front.sv @@
// Front part: takes received bytes, holds the mode register and classifies each byte.
module lde_front import lde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_realtime_mode;
    logic [7:0] r_prev_byte;
    logic       accept;
    logic       is_line_end;
    logic       is_print;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign accept      = i_in_valid && !i_q_full;

    // Mode register and the previous byte, which tracks every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_realtime_mode <= 1'b0;
            r_prev_byte     <= 8'h00;
        end else begin
            if (i_cfg_valid) begin
                r_realtime_mode <= i_cfg_data;
            end
            if (accept) begin
                r_prev_byte <= i_in_byte;
            end
        end
    end

    // Classify the byte into a command; ignored bytes push nothing.
    assign is_line_end = (i_in_byte == BYTE_CR) || (i_in_byte == BYTE_LF);
    assign is_print    = (i_in_byte >= PRINT_LOW) && (i_in_byte < PRINT_END);

    always_comb begin
        o_cmd.data        = i_in_byte;
        o_cmd.lf_after_cr = (i_in_byte == BYTE_LF) && (r_prev_byte == BYTE_CR);
        o_cmd.op          = OP_PASS;
        o_push            = 1'b0;
        if (r_realtime_mode) begin
            o_cmd.op = OP_PASS;
            o_push   = accept;
        end else if (is_line_end) begin
            o_cmd.op = OP_END;
            o_push   = accept;
        end else if (i_in_byte == BYTE_BS) begin
            o_cmd.op = OP_BS;
            o_push   = accept;
        end else if (is_print) begin
            o_cmd.op = OP_PUT;
            o_push   = accept;
        end
    end

endmodule

@@ rtl/core/lde_queue.sv @@
// Short command queue between the front and back parts.
module lde_queue import lde_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/lde_back.sv @@
// Back part: carries out commands on the line store and drives the result register.
module lde_back import lde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_result_kind,
    output logic       o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_byte;
    logic [1:0]        r_out_kind;
    logic              r_out_last;

    logic              out_free;
    logic              load;
    logic [7:0]        load_byte;
    logic [1:0]        load_kind;
    logic              load_last;
    logic              wr_en;
    logic              rd_en;
    logic [7:0]        rd_data;
    logic              store_full;
    logic [LEN_W-1:0]  idx_next;

    // Line store.
    lde_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_len[ADDR_W-1:0]),
        .i_wr_data(i_q_cmd.data),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign store_full = (r_len == LEN_W'(LINE_CAPACITY));
    assign idx_next   = LEN_W'(r_idx) + LEN_W'(1);

    // Command sequencer.
    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_idx     = r_idx;
        o_pop     = 1'b0;
        load      = 1'b0;
        load_byte = i_q_cmd.data;
        load_kind = KIND_REALTIME;
        load_last = 1'b1;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        OP_PASS: begin
                            if (out_free) begin
                                load  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                        OP_END: begin
                            if (r_len != '0) begin
                                o_pop   = 1'b1;
                                n_idx   = '0;
                                n_state = S_READ;
                            end else if (i_q_cmd.lf_after_cr) begin
                                o_pop = 1'b1;
                            end else if (out_free) begin
                                load      = 1'b1;
                                load_byte = 8'h00;
                                load_kind = KIND_EMPTY;
                                o_pop     = 1'b1;
                            end
                        end
                        OP_BS: begin
                            o_pop = 1'b1;
                            if (r_len != '0) begin
                                n_len = r_len - LEN_W'(1);
                            end
                        end
                        OP_PUT: begin
                            o_pop = 1'b1;
                            if (!store_full) begin
                                wr_en = 1'b1;
                                n_len = r_len + LEN_W'(1);
                            end
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    load      = 1'b1;
                    load_byte = rd_data;
                    load_kind = KIND_LINE_CHAR;
                    load_last = (idx_next == r_len);
                    if (idx_next == r_len) begin
                        n_len   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result register valid flag.
    always_comb begin
        if (load) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && !i_out_ready;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= load_byte;
            r_out_kind <= load_kind;
            r_out_last <= load_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_result_kind = r_out_kind;
    assign o_last        = r_out_last;

endmodule

@@ rtl/core/line_editor_with_backspace.sv @@
// Top level of the line editor: front classifier, command queue and back executor.
//
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | o_out_byte, o_result_kind, o_last
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (realtime mode)
//
// The front takes one byte per cycle while the two-entry command queue has room.
// The back retires a store, backspace or pass command from S_IDLE; a line end walks
// the line store character by character (RAM read in S_READ, result load in S_EMIT).
// Reset is synchronous and active low; the store contents are undefined after reset.
// A stalled output holds the result register and backs up through the queue.
module line_editor_with_backspace import lde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic [1:0] o_result_kind,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    // Classifier.
    lde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Command queue.
    lde_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .o_valid(q_valid),
        .i_pop  (pop),
        .o_cmd  (head_cmd)
    );

    // Executor and result register.
    lde_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_cmd      (head_cmd),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_result_kind(o_result_kind),
        .o_last       (o_last)
    );

endmodule

@@ sim/tb_line_editor_with_backspace.sv @@
// Self-checking testbench for the line editor: directed and random byte streams.
module tb_line_editor_with_backspace;
    import lde_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;

    // One result item as seen on the output channel.
    typedef struct {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       last;
    } line_result_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic [1:0] o_result_kind;
    logic       o_last;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    // Editor state as the testbench expects it.
    logic [7:0]   line_buf [LINE_CAPACITY];
    int           line_len;
    logic [7:0]   prev_byte;
    logic         rt_mode;
    line_result_t pending_results[$];

    int n_errors;
    int n_effective;
    int idle_cycles;
    bit steady_flow;

    line_editor_with_backspace u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_byte     (i_in_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_result_kind (o_result_kind),
        .o_last        (o_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Gap length for the sender: mostly none, a few long.
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Stall length for the receiver: mostly short, a few long.
    function automatic int stall_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] printable_byte();
        return 8'($urandom_range(PRINT_LOW, PRINT_END - 1));
    endfunction

    // A byte that line mode ignores: stray control codes or the upper range.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(PRINT_END, 8'hff));
        do b = 8'($urandom_range(0, PRINT_LOW - 1));
        while (b == BYTE_CR || b == BYTE_LF || b == BYTE_BS);
        return b;
    endfunction

    // Works out the results that one accepted byte causes.
    function automatic void editor_predict(logic [7:0] b);
        line_result_t res;
        if (rt_mode) begin
            res = '{b, KIND_REALTIME, 1'b1};
            pending_results.push_back(res);
            n_effective++;
        end else if (b == BYTE_CR || b == BYTE_LF) begin
            n_effective++;
            if (line_len == 0) begin
                if (!(b == BYTE_LF && prev_byte == BYTE_CR)) begin
                    res = '{8'h00, KIND_EMPTY, 1'b1};
                    pending_results.push_back(res);
                end
            end else begin
                for (int i = 0; i < line_len; i++) begin
                    res = '{line_buf[i], KIND_LINE_CHAR, (i == line_len - 1)};
                    pending_results.push_back(res);
                end
                line_len = 0;
            end
        end else if (b == BYTE_BS) begin
            n_effective++;
            if (line_len > 0) line_len--;
        end else if (b >= PRINT_LOW && b < PRINT_END) begin
            n_effective++;
            if (line_len < LINE_CAPACITY) begin
                line_buf[line_len] = b;
                line_len++;
            end
        end
        prev_byte = b;
    endfunction

    // Sends one item and records its expected results once accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        editor_predict(b);
    endtask

    // Stops sending and waits until every expected result has come out.
    task automatic wait_line_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the mode register once the block has gone quiet.
    task automatic write_mode(input logic mode);
        wait_line_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        rt_mode = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Line mode corners: empty lines, CR followed by LF, edits and ignored bytes.
    task automatic test_line_corners();
        logic [7:0] seq[$];
        seq = '{BYTE_CR, BYTE_LF, BYTE_LF, BYTE_BS, 8'h20, 8'h7e, 8'h1f, 8'h7f, 8'hff,
                8'h00, 8'h41, BYTE_BS, 8'h42, BYTE_LF, 8'h78, BYTE_CR, BYTE_LF};
        steady_flow = 1'b0;
        write_mode(1'b0);
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    // The store survives realtime mode, and the previous byte tracks both modes.
    task automatic test_mode_switch();
        logic [7:0] rt_seq[$];
        rt_seq = '{8'h00, 8'hff, BYTE_LF, BYTE_BS, BYTE_CR};
        send_byte(8'h68);
        send_byte(8'h69);
        write_mode(1'b1);
        foreach (rt_seq[i]) send_byte(rt_seq[i]);
        write_mode(1'b0);
        send_byte(BYTE_LF);
        write_mode(1'b1);
        send_byte(BYTE_CR);
        write_mode(1'b0);
        send_byte(BYTE_LF);
        send_byte(BYTE_CR);
    endtask

    // Random edited lines, with an overfull line first to hit the capacity limit.
    task automatic test_random_lines(input int target);
        int base;
        int len;
        int r;
        base = n_effective;
        write_mode(1'b0);
        for (int k = 0; k < LINE_CAPACITY + 4; k++) send_byte(printable_byte());
        send_byte(BYTE_CR);
        while (n_effective - base < target) begin
            steady_flow = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12)
                                               : $urandom_range(40, LINE_CAPACITY + 6);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (r < 8) send_byte(BYTE_BS);
                else if (r < 12) send_byte(noise_byte());
                else send_byte(printable_byte());
            end
            r = $urandom_range(0, 2);
            if (r != 1) send_byte(BYTE_CR);
            if (r != 0) send_byte(BYTE_LF);
            // Now and then let the output side drain completely.
            if ($urandom_range(0, 7) == 0) wait_line_idle();
        end
        steady_flow = 1'b0;
    endtask

    // Realtime pass-through of arbitrary bytes.
    task automatic test_random_realtime(input int target);
        int base;
        base = n_effective;
        write_mode(1'b1);
        while (n_effective - base < target) begin
            if ($urandom_range(0, 19) == 0) steady_flow = ~steady_flow;
            send_byte(8'($urandom_range(0, 255)));
        end
        steady_flow = 1'b0;
    endtask

    // Short bursts under random mode changes.
    task automatic test_random_mixed(input int target);
        int base;
        int r;
        int burst;
        base = n_effective;
        while (n_effective - base < target) begin
            write_mode(1'($urandom_range(0, 1)));
            burst = $urandom_range(5, 20);
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) send_byte(BYTE_CR);
                else if (r < 20) send_byte(BYTE_LF);
                else if (r < 30) send_byte(BYTE_BS);
                else if (r < 80) send_byte(printable_byte());
                else send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: random stalls, or always ready during steady stretches.
    initial begin
        int hold;
        hold = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (steady_flow) begin
                i_out_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (i_out_ready && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                hold = stall_len();
            end else begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        line_result_t exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result byte %02h kind %0d last %0b",
                         $time, o_out_byte, o_result_kind, o_last);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out_byte !== exp_res.ch) begin
                    $display("%0t: out_byte expected %02h got %02h",
                             $time, exp_res.ch, o_out_byte);
                    n_errors++;
                end
                if (o_result_kind !== exp_res.kind) begin
                    $display("%0t: result_kind expected %0d got %0d",
                             $time, exp_res.kind, o_result_kind);
                    n_errors++;
                end
                if (o_last !== exp_res.last) begin
                    $display("%0t: last expected %0b got %0b",
                             $time, exp_res.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("line_editor_with_backspace test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_byte   = 8'h00;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        line_len    = 0;
        prev_byte   = 8'h00;
        rt_mode     = 1'b0;
        n_errors    = 0;
        n_effective = 0;
        idle_cycles = 0;
        steady_flow = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_line_corners();
        test_mode_switch();
        test_random_lines(300);
        test_random_realtime(60);
        test_random_mixed(100);
        wait_line_idle();

        if (n_errors == 0) begin
            $display("line_editor_with_backspace test passed");
        end else begin
            $display("line_editor_with_backspace test failed");
        end
        $finish;
    end

endmodule
